// ===== sv/cpbpf_pkg.sv =====
// ============================================================================
// cpbpf_pkg: shared definitions for the contact pair broad-phase filter
// Parameter defaults, request function codes, register indexes and the
// status group that the geometry unit returns to the top level.
// ============================================================================
package cpbpf_pkg;

   // Defaults for the top-level parameters.
   localparam int LIST_DEPTH_DEFAULT = 16;
   localparam int ID_BITS_DEFAULT    = 8;
   localparam int POS_BITS_DEFAULT   = 24;

   // Fixed field widths.
   localparam int RADIUS_BITS    = 23;
   localparam int FUNC_BITS      = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int RSP_TDATA_BITS = 8;

   // Request function codes, carried on req_tuser.
   localparam logic [FUNC_BITS-1:0] FUNC_QUERY       = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_ADD_BANNED  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_ADD_ALLOWED = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OWN_CHECK_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OWN_RADIUS       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OWN_CENTER_X     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OWN_CENTER_Y     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OWN_CENTER_Z     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROHIBIT_MODE    = 3'd5;

   // Status of the geometry unit as seen by the top level.
   typedef struct packed {
      logic busy;
      logic pass;
   } geom_status_type;

endpackage

// ===== sv/cpbpf_geom.sv =====
// ============================================================================
// cpbpf_geom: sphere pair geometry test
// For each axis in turn, checks the strict box overlap and then squares and adds the
// centre offset through one shared multiplier; at the end compares the sum of squares
// with the square of the radius sum.
// ============================================================================
module cpbpf_geom #(
   parameter int POS_BITS = cpbpf_pkg::POS_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [cpbpf_pkg::RADIUS_BITS-1:0] own_radius,
   input  logic signed [POS_BITS-1:0]        own_center_x,
   input  logic signed [POS_BITS-1:0]        own_center_y,
   input  logic signed [POS_BITS-1:0]        own_center_z,
   input  logic [cpbpf_pkg::RADIUS_BITS-1:0] other_radius,
   input  logic signed [POS_BITS-1:0]        other_center_x,
   input  logic signed [POS_BITS-1:0]        other_center_y,
   input  logic signed [POS_BITS-1:0]        other_center_z,
   output cpbpf_pkg::geom_status_type        status
);

   localparam int MAG_BITS  = cpbpf_pkg::RADIUS_BITS + 1;
   localparam int DIFF_BITS = POS_BITS + 1;
   localparam int CMP_BITS  = (DIFF_BITS > MAG_BITS) ? DIFF_BITS : MAG_BITS;
   localparam int PROD_BITS = 2 * MAG_BITS;
   localparam int ACC_BITS  = PROD_BITS + 2;
   localparam logic [1:0] LAST_AXIS = 2'd2;

   typedef enum logic [5:0] {
      G_IDLE    = 6'b000001,
      G_AXIS    = 6'b000010,
      G_SQUARE  = 6'b000100,
      G_ACCUM   = 6'b001000,
      G_LIMIT   = 6'b010000,
      G_COMPARE = 6'b100000
   } geom_state_type;

   geom_state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic pass_ff, pass_in;
   logic [MAG_BITS-1:0] rsum_ff, rsum_in;
   logic [MAG_BITS-1:0] mag_ff, mag_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [ACC_BITS-1:0] acc_ff, acc_in;
   logic signed [POS_BITS-1:0] oth_x_ff, oth_y_ff, oth_z_ff;

   logic signed [POS_BITS-1:0] own_c, oth_c;
   logic signed [DIFF_BITS-1:0] diff;
   logic [DIFF_BITS-1:0] abs_diff;
   logic [CMP_BITS-1:0] abs_ext, rsum_ext;
   logic box_reject;

   // Select the current axis and form the magnitude of the centre offset.
   always_comb begin
      unique case (axis_ff)
         2'd0:    begin own_c = own_center_x; oth_c = oth_x_ff; end
         2'd1:    begin own_c = own_center_y; oth_c = oth_y_ff; end
         default: begin own_c = own_center_z; oth_c = oth_z_ff; end
      endcase
      diff = {own_c[POS_BITS-1], own_c} - {oth_c[POS_BITS-1], oth_c};
      abs_diff = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
      abs_ext = CMP_BITS'(abs_diff);
      rsum_ext = CMP_BITS'(rsum_ff);
      // Both box conditions reduce to the offset reaching the radius sum.
      box_reject = (abs_ext >= rsum_ext);
   end

   // Sequencer: box step and square/accumulate per axis, then the limit.
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      pass_in  = pass_ff;
      rsum_in  = rsum_ff;
      mag_in   = mag_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      unique case (state_ff)
         G_IDLE: begin
            if (start) begin
               rsum_in  = MAG_BITS'(own_radius) + MAG_BITS'(other_radius);
               axis_in  = 2'd0;
               acc_in   = '0;
               state_in = G_AXIS;
            end
         end
         G_AXIS: begin
            if (box_reject) begin
               pass_in  = 1'b0;
               state_in = G_IDLE;
            end else begin
               mag_in   = abs_ext[MAG_BITS-1:0];
               state_in = G_SQUARE;
            end
         end
         G_SQUARE: begin
            prod_in  = PROD_BITS'(mag_ff) * PROD_BITS'(mag_ff);
            state_in = G_ACCUM;
         end
         G_ACCUM: begin
            acc_in = acc_ff + ACC_BITS'(prod_ff);
            if (axis_ff == LAST_AXIS) begin
               mag_in   = rsum_ff;
               state_in = G_LIMIT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = G_AXIS;
            end
         end
         G_LIMIT: begin
            prod_in  = PROD_BITS'(mag_ff) * PROD_BITS'(mag_ff);
            state_in = G_COMPARE;
         end
         G_COMPARE: begin
            pass_in  = (acc_ff < ACC_BITS'(prod_ff));
            state_in = G_IDLE;
         end
         default: begin
            state_in = G_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         axis_ff  <= 2'd0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         pass_ff  <= pass_in;
      end
   end

   // Datapath registers; the other centre is captured at start.
   always_ff @(posedge clock) begin
      rsum_ff <= rsum_in;
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (start && (state_ff == G_IDLE)) begin
         oth_x_ff <= other_center_x;
         oth_y_ff <= other_center_y;
         oth_z_ff <= other_center_z;
      end
   end

   assign status.busy = (state_ff != G_IDLE);
   assign status.pass = pass_ff;

   // A new test is only started once the previous one has finished.
   assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == G_IDLE))
      else $error("geometry unit started while busy");

   // The comparison step always returns the unit to idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == G_COMPARE) |=> (state_ff == G_IDLE))
      else $error("geometry unit did not finish after the comparison");

   // The axis counter never passes the last axis.
   assert property (@(posedge clock) disable iff (reset)
      (axis_ff == 2'd0) || (axis_ff == 2'd1) || (axis_ff == LAST_AXIS))
      else $error("geometry axis counter out of range");

endmodule

// ===== sv/contact_pair_broad_phase_filter.sv =====
// An add or unused code moves from the idle state to the result state; its result beat is then
// loaded into the output register once that register is empty or being read. A query waits in
// the query state until the walk of the selected table and the geometry unit's multiply sequence
// have both finished; the id memory is read one entry per cycle. Items are taken one at a time;
// the next request beat is taken in the cycle after the result is loaded into the output register.
// Reset (synchronous, active high) empties both tables and restores register defaults.
// ============================================================================
// contact_pair_broad_phase_filter: bounding sphere broad-phase contact filter
// Keeps banned and allowed id tables in one synchronous memory, applies the
// list rule by walking the selected table, and runs the sphere pair test in
// a separate multi-cycle geometry unit.
// ============================================================================
module contact_pair_broad_phase_filter #(
   parameter int LIST_DEPTH = cpbpf_pkg::LIST_DEPTH_DEFAULT,
   parameter int ID_BITS    = cpbpf_pkg::ID_BITS_DEFAULT,
   parameter int POS_BITS   = cpbpf_pkg::POS_BITS_DEFAULT,
   localparam int IN_BITS   = ID_BITS + 1 + cpbpf_pkg::RADIUS_BITS + 3 * POS_BITS,
   localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8,
   localparam int CSR_DATA_BITS =
      (POS_BITS > cpbpf_pkg::RADIUS_BITS) ? POS_BITS : cpbpf_pkg::RADIUS_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // other_id, other_check_enable, other_radius, other_center_x, _y, _z
   input  logic [IN_TDATA_BITS-1:0]             req_tdata,
   // func
   input  logic [cpbpf_pkg::FUNC_BITS-1:0]      req_tuser,
   // Result stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // possible, status
   output logic [cpbpf_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // Register write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cpbpf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]             csr_data
);

   localparam int RB        = cpbpf_pkg::RADIUS_BITS;
   localparam int OFF_EN    = ID_BITS;
   localparam int OFF_RAD   = ID_BITS + 1;
   localparam int OFF_X     = OFF_RAD + RB;
   localparam int OFF_Y     = OFF_X + POS_BITS;
   localparam int OFF_Z     = OFF_Y + POS_BITS;
   localparam int CNT_BITS  = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_BITS = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int MEM_DEPTH = 2 ** (ADDR_BITS + 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(LIST_DEPTH);
   // Table select bit in the memory address.
   localparam logic TBL_BANNED  = 1'b0;
   localparam logic TBL_ALLOWED = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_QUERY  = 3'b010,
      S_RESULT = 3'b100
   } state_type;

   // Request fields.
   logic [cpbpf_pkg::FUNC_BITS-1:0] req_func;
   logic [ID_BITS-1:0] req_id;
   logic req_check_enable;
   logic [RB-1:0] req_radius;
   logic signed [POS_BITS-1:0] req_cx, req_cy, req_cz;
   logic req_accept;

   // Configuration registers.
   logic own_check_enable_ff;
   logic [RB-1:0] own_radius_ff;
   logic signed [POS_BITS-1:0] own_center_x_ff, own_center_y_ff, own_center_z_ff;
   logic prohibit_mode_ff;

   // Control and item state.
   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] banned_count_ff, banned_count_in;
   logic [CNT_BITS-1:0] allowed_count_ff, allowed_count_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic rd_pend_ff, rd_pend_in;
   logic hit_ff, hit_in;
   logic res_possible_ff, res_possible_in;
   logic res_status_ff, res_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_possible_ff, rsp_status_ff;
   logic [ID_BITS-1:0] id_ff;
   logic oth_en_ff;

   // Memory ports.
   logic [ID_BITS-1:0] id_mem [MEM_DEPTH];
   logic [ID_BITS-1:0] mem_rd_ff;
   logic mem_we;
   logic [ADDR_BITS:0] mem_wa, mem_ra;
   logic [ID_BITS-1:0] mem_wd;

   logic [CNT_BITS-1:0] sel_count;
   logic walking, list_ok, geom_ok, geom_start, rsp_load;
   cpbpf_pkg::geom_status_type geom_stat;

   // Unpack the request beat.
   assign req_func         = req_tuser;
   assign req_id           = req_tdata[ID_BITS-1:0];
   assign req_check_enable = req_tdata[OFF_EN];
   assign req_radius       = req_tdata[OFF_X-1:OFF_RAD];
   assign req_cx           = req_tdata[OFF_Y-1:OFF_X];
   assign req_cy           = req_tdata[OFF_Z-1:OFF_Y];
   assign req_cz           = req_tdata[OFF_Z+POS_BITS-1:OFF_Z];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Register writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_check_enable_ff <= 1'b0;
         own_radius_ff       <= '0;
         own_center_x_ff     <= '0;
         own_center_y_ff     <= '0;
         own_center_z_ff     <= '0;
         prohibit_mode_ff    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cpbpf_pkg::CSR_OWN_CHECK_ENABLE: own_check_enable_ff <= csr_data[0];
            cpbpf_pkg::CSR_OWN_RADIUS:       own_radius_ff <= csr_data[RB-1:0];
            cpbpf_pkg::CSR_OWN_CENTER_X:     own_center_x_ff <= csr_data[POS_BITS-1:0];
            cpbpf_pkg::CSR_OWN_CENTER_Y:     own_center_y_ff <= csr_data[POS_BITS-1:0];
            cpbpf_pkg::CSR_OWN_CENTER_Z:     own_center_z_ff <= csr_data[POS_BITS-1:0];
            cpbpf_pkg::CSR_PROHIBIT_MODE:    prohibit_mode_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Table walk: the selected table is read one entry per cycle.
   assign sel_count = prohibit_mode_ff ? banned_count_ff : allowed_count_ff;
   assign walking   = (idx_ff < sel_count);
   assign mem_ra    = {(prohibit_mode_ff ? TBL_BANNED : TBL_ALLOWED),
                       idx_ff[ADDR_BITS-1:0]};
   assign list_ok   = prohibit_mode_ff ? !hit_ff : hit_ff;
   assign geom_ok   = !(own_check_enable_ff && oth_en_ff) || geom_stat.pass;
   assign rsp_load  = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp_tready);
   assign geom_start = req_accept && (req_func == cpbpf_pkg::FUNC_QUERY);

   // Item sequencing, table appends and the result hand-off.
   always_comb begin
      state_in         = state_ff;
      banned_count_in  = banned_count_ff;
      allowed_count_in = allowed_count_ff;
      idx_in           = idx_ff;
      rd_pend_in       = rd_pend_ff;
      hit_in           = hit_ff;
      res_possible_in  = res_possible_ff;
      res_status_in    = res_status_ff;
      mem_we           = 1'b0;
      mem_wa           = {TBL_BANNED, banned_count_ff[ADDR_BITS-1:0]};
      mem_wd           = req_id;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_possible_in = 1'b0;
               res_status_in   = 1'b0;
               state_in        = S_RESULT;
               unique case (req_func)
                  cpbpf_pkg::FUNC_QUERY: begin
                     idx_in     = '0;
                     rd_pend_in = 1'b0;
                     hit_in     = 1'b0;
                     state_in   = S_QUERY;
                  end
                  cpbpf_pkg::FUNC_ADD_BANNED: begin
                     if (banned_count_ff < DEPTH_CNT) begin
                        mem_we          = 1'b1;
                        banned_count_in = banned_count_ff + CNT_BITS'(1);
                     end else begin
                        res_status_in = 1'b1;
                     end
                  end
                  cpbpf_pkg::FUNC_ADD_ALLOWED: begin
                     mem_wa = {TBL_ALLOWED, allowed_count_ff[ADDR_BITS-1:0]};
                     if (allowed_count_ff < DEPTH_CNT) begin
                        mem_we           = 1'b1;
                        allowed_count_in = allowed_count_ff + CNT_BITS'(1);
                     end else begin
                        res_status_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_QUERY: begin
            rd_pend_in = walking;
            if (walking) begin
               idx_in = idx_ff + CNT_BITS'(1);
            end
            if (rd_pend_ff && (mem_rd_ff == id_ff)) begin
               hit_in = 1'b1;
            end
            if (!walking && !rd_pend_ff && !geom_stat.busy) begin
               res_possible_in = list_ok && geom_ok;
               state_in        = S_RESULT;
            end
         end
         S_RESULT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         banned_count_ff  <= '0;
         allowed_count_ff <= '0;
         idx_ff           <= '0;
         rd_pend_ff       <= 1'b0;
         hit_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         banned_count_ff  <= banned_count_in;
         allowed_count_ff <= allowed_count_in;
         idx_ff           <= idx_in;
         rd_pend_ff       <= rd_pend_in;
         hit_ff           <= hit_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      res_possible_ff <= res_possible_in;
      res_status_ff   <= res_status_in;
      if (req_accept) begin
         id_ff     <= req_id;
         oth_en_ff <= req_check_enable;
      end
      if (rsp_load) begin
         rsp_possible_ff <= res_possible_ff;
         rsp_status_ff   <= res_status_ff;
      end
   end

   // Id memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         id_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= id_mem[mem_ra];
   end

   cpbpf_geom #(
      .POS_BITS(POS_BITS)
   ) u_geom (
      .clock          (clock),
      .reset          (reset),
      .start          (geom_start),
      .own_radius     (own_radius_ff),
      .own_center_x   (own_center_x_ff),
      .own_center_y   (own_center_y_ff),
      .own_center_z   (own_center_z_ff),
      .other_radius   (req_radius),
      .other_center_x (req_cx),
      .other_center_y (req_cy),
      .other_center_z (req_cz),
      .status         (geom_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(cpbpf_pkg::RSP_TDATA_BITS - 2){1'b0}},
                        rsp_status_ff, rsp_possible_ff};

   // The geometry unit only runs while a query is in progress.
   assert property (@(posedge clock) disable iff (reset)
      geom_stat.busy |-> (state_ff == S_QUERY))
      else $error("geometry unit busy outside a query");

   // Neither table count ever passes the table depth.
   assert property (@(posedge clock) disable iff (reset)
      (banned_count_ff <= DEPTH_CNT) && (allowed_count_ff <= DEPTH_CNT))
      else $error("id table count beyond depth");

   // An add to a full banned table leaves its count unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_func == cpbpf_pkg::FUNC_ADD_BANNED)
       && (banned_count_ff == DEPTH_CNT)) |=> $stable(banned_count_ff))
      else $error("add to a full table changed its count");

   // A result beat is only raised from the result state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT))
      else $error("result raised outside the result state");

endmodule
